// ----- rtl/gbn_pkg.sv -----
// Shared types and constants for the Go-Back-N sender window.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int FrameW = 16;
  localparam int AckW = 16;
  localparam int KindW = 2;
  localparam int WinW = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;
  localparam int CmdDepth = 2;

  // Event kinds.
  localparam logic [KindW-1:0] KindStart   = 2'd0;
  localparam logic [KindW-1:0] KindAck     = 2'd1;
  localparam logic [KindW-1:0] KindTimeout = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWindowSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameCount = 1'b1;

  localparam logic [WinW-1:0] WindowSizeReset = 6'd4;
  localparam logic [FrameW-1:0] FrameCountReset = 16'd16;

  // Frame number carried by the end-of-transfer notice.
  localparam logic [FrameW-1:0] EndFrame = 16'hFFFF;

  typedef struct packed {
    logic [WinW-1:0]   window_size;
    logic [FrameW-1:0] frame_count;
  } cfg_t;

  // One burst for the back end: frames first_frame through last_frame, or the end notice.
  typedef struct packed {
    logic [FrameW-1:0] first_frame;
    logic [FrameW-1:0] last_frame;
    logic              end_marker;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/gbn_if.sv -----
// Event and result channel interfaces of the Go-Back-N sender window.
`timescale 1ns / 1ps
`default_nettype none

interface gbn_evt_if;
  logic                     valid;
  logic                     ready;
  logic [gbn_pkg::KindW-1:0] kind;
  logic [gbn_pkg::AckW-1:0]  ack_number;

  modport source (output valid, output kind, output ack_number, input ready);
  modport sink (input valid, input kind, input ack_number, output ready);
endinterface

interface gbn_res_if;
  logic                       valid;
  logic                       ready;
  logic [gbn_pkg::FrameW-1:0] frame_number;
  logic                       end_marker;
  logic                       last;

  modport source (output valid, output frame_number, output end_marker, output last,
                  input ready);
  modport sink (input valid, input frame_number, input end_marker, input last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/gbn_front.sv -----
// Front end: accepts events, keeps the window state and issues burst commands.
`timescale 1ns / 1ps
`default_nettype none

module gbn_front #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_WIDTH  = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gbn_evt_if.sink            evt_i,
  input  wire gbn_pkg::cfg_t cfg_i,
  input  wire logic          full_i,
  output logic               push_o,
  output gbn_pkg::cmd_t      cmd_o
);

  // Frame numbers never exceed the frame count, which is 16 bits wide.
  localparam int SeqW = (SEQ_WIDTH < gbn_pkg::FrameW) ? SEQ_WIDTH : gbn_pkg::FrameW;
  localparam logic [SeqW-1:0] SeqMax = {SeqW{1'b1}};
  localparam logic [6:0] MaxWin = 7'(MAX_WINDOW);

  logic [SeqW-1:0] base_q, base_d;
  logic [SeqW-1:0] top_q, top_d;
  logic            active_q, active_d;

  logic [SeqW-1:0] count;
  logic [6:0]      ws;
  logic [16:0]     span;
  logic [SeqW:0]   base_inc;
  logic [SeqW:0]   top_inc;
  logic            accept;

  assign evt_i.ready = !full_i;
  assign accept = evt_i.valid && evt_i.ready;

  always_comb begin
    count = (cfg_i.frame_count > gbn_pkg::FrameW'(SeqMax)) ? SeqMax
                                                          : cfg_i.frame_count[SeqW-1:0];
    ws = {1'b0, cfg_i.window_size};
    if (ws == 7'd0) begin
      ws = 7'd1;
    end
    if (ws > MaxWin) begin
      ws = MaxWin;
    end
    span = (17'(ws) < 17'(count)) ? 17'(ws) : 17'(count);
    base_inc = {1'b0, base_q} + {{SeqW{1'b0}}, 1'b1};
    top_inc  = {1'b0, top_q} + {{SeqW{1'b0}}, 1'b1};

    base_d   = base_q;
    top_d    = top_q;
    active_d = active_q;
    push_o   = 1'b0;
    cmd_o    = '{first_frame: gbn_pkg::FrameW'(base_q),
                 last_frame: gbn_pkg::FrameW'(top_q),
                 end_marker: 1'b0};

    if (accept) begin
      unique case (evt_i.kind) inside
        gbn_pkg::KindStart: begin
          base_d = '0;
          push_o = 1'b1;
          if (count == '0) begin
            top_d    = '0;
            active_d = 1'b0;
            cmd_o    = '{first_frame: gbn_pkg::EndFrame, last_frame: gbn_pkg::EndFrame,
                         end_marker: 1'b1};
          end else begin
            top_d    = SeqW'(span - 17'd1);
            active_d = 1'b1;
            cmd_o    = '{first_frame: '0, last_frame: gbn_pkg::FrameW'(top_d),
                         end_marker: 1'b0};
          end
        end
        gbn_pkg::KindAck, gbn_pkg::KindTimeout: begin
          if (active_q) begin
            if (evt_i.kind == gbn_pkg::KindAck &&
                evt_i.ack_number[SeqW-1:0] == base_inc[SeqW-1:0]) begin
              // In-order acknowledgement: slide the window by one.
              base_d = base_inc[SeqW-1:0];
              if (base_inc >= {1'b0, count}) begin
                active_d = 1'b0;
                push_o   = 1'b1;
                cmd_o    = '{first_frame: gbn_pkg::EndFrame, last_frame: gbn_pkg::EndFrame,
                             end_marker: 1'b1};
              end else if (top_inc < {1'b0, count}) begin
                top_d  = top_inc[SeqW-1:0];
                push_o = 1'b1;
                cmd_o  = '{first_frame: gbn_pkg::FrameW'(top_inc[SeqW-1:0]),
                           last_frame: gbn_pkg::FrameW'(top_inc[SeqW-1:0]),
                           end_marker: 1'b0};
              end
            end else begin
              // Out-of-order acknowledgement or timeout: resend the whole window.
              push_o = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      top_q    <= '0;
      active_q <= 1'b0;
    end else begin
      base_q   <= base_d;
      top_q    <= top_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gbn_cmd_fifo.sv -----
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module gbn_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gbn_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               avail_o,
  output gbn_pkg::cmd_t      cmd_o
);

  localparam int PtrW = (gbn_pkg::CmdDepth > 1) ? $clog2(gbn_pkg::CmdDepth) : 1;
  localparam int CntW = $clog2(gbn_pkg::CmdDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(gbn_pkg::CmdDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(gbn_pkg::CmdDepth - 1);

  gbn_pkg::cmd_t   slots_q [gbn_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign cmd_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gbn_back.sv -----
// Back end: plays out one burst command as a run of result items.
`timescale 1ns / 1ps
`default_nettype none

module gbn_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gbn_res_if.source          res_o,
  input  wire logic          avail_i,
  input  wire gbn_pkg::cmd_t cmd_i,
  output logic               pop_o
);

  logic [gbn_pkg::FrameW-1:0] cur_q, last_q;
  logic                       end_q;
  logic                       busy_q;
  logic                       done;
  logic                       fire;
  logic                       free;

  assign done  = end_q || (cur_q == last_q);
  assign fire  = res_o.valid && res_o.ready;
  assign free  = !busy_q || (fire && done);
  assign pop_o = free && avail_i;

  assign res_o.valid        = busy_q;
  assign res_o.frame_number = cur_q;
  assign res_o.end_marker   = end_q;
  assign res_o.last         = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
    end else if (fire && done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= cmd_i.first_frame;
      last_q <= cmd_i.last_frame;
      end_q  <= cmd_i.end_marker;
    end else if (fire && !done) begin
      cur_q <= cur_q + gbn_pkg::FrameW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/go_back_n_sender_window_top.sv -----
// Top level of the Go-Back-N sender window: configuration, front end, queue and back end.
// A result item is offered once its event has passed the command queue into the result
// register. Throughput: one event per cycle while the two-entry command queue has room;
// the back end plays out one frame per cycle while the receiver is ready, so a start or
// rewind yields one item per window frame, a slide or the end notice a single item.
// Reset clears window state, queue and result register and loads window 4, 16 frames.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window_top #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_WIDTH  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  gbn_evt_if.sink                            evt_i,
  gbn_res_if.source                          res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [gbn_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // Configuration registers: users write them only while the block is idle; not enforced.
  logic [gbn_pkg::WinW-1:0]   window_size_q;
  logic [gbn_pkg::FrameW-1:0] frame_count_q;
  gbn_pkg::cfg_t              cfg;

  // Handoff between the front end and the back end through the queue.
  logic          push;
  gbn_pkg::cmd_t push_cmd;
  logic          full;
  logic          pop;
  logic          avail;
  gbn_pkg::cmd_t head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= gbn_pkg::WindowSizeReset;
      frame_count_q <= gbn_pkg::FrameCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gbn_pkg::CfgWindowSize: window_size_q <= cfg_wdata_i[gbn_pkg::WinW-1:0];
        gbn_pkg::CfgFrameCount: frame_count_q <= cfg_wdata_i[gbn_pkg::FrameW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{window_size: window_size_q, frame_count: frame_count_q};

  // The front end settles each event in the cycle it is accepted and queues the burst
  // of frames it calls for; events that cause no result leave the queue alone.
  gbn_front #(
    .MAX_WINDOW(MAX_WINDOW),
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_i),
    .cfg_i (cfg),
    .full_i(full),
    .push_o(push),
    .cmd_o (push_cmd)
  );

  gbn_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .avail_o(avail),
    .cmd_o  (head_cmd)
  );

  // The back end holds the result register and steps through each burst, marking the
  // final item of a burst as last.
  gbn_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_o  (res_o),
    .avail_i(avail),
    .cmd_i  (head_cmd),
    .pop_o  (pop)
  );

endmodule

`default_nettype wire

// ----- rtl/gbn_checker.sv -----
// Port-level assertions for the Go-Back-N sender window and their bind.
`timescale 1ns / 1ps
`default_nettype none

module gbn_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       res_valid_i,
  input wire logic                       res_ready_i,
  input wire logic [gbn_pkg::FrameW-1:0] res_frame_number_i,
  input wire logic                       res_end_marker_i,
  input wire logic                       res_last_i
);

  // A result item stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  // The end notice stands alone and carries the all-ones frame number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_end_marker_i |->
      res_last_i && res_frame_number_i == gbn_pkg::EndFrame)
    else $error("malformed end-of-transfer item");

  // Real frames never use the frame number reserved for the end notice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_end_marker_i |-> res_frame_number_i != gbn_pkg::EndFrame)
    else $error("frame carries the end frame number");

  // Within a burst, frames follow one another without gaps in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=>
      res_valid_i && !res_end_marker_i &&
      res_frame_number_i == $past(res_frame_number_i) + gbn_pkg::FrameW'(1))
    else $error("burst frames out of sequence");

endmodule

bind go_back_n_sender_window_top gbn_checker u_gbn_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_frame_number_i(res_o.frame_number),
  .res_end_marker_i  (res_o.end_marker),
  .res_last_i        (res_o.last)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the Go-Back-N sender window: predicted frame items against the results.
module tb_top;

  localparam int MaxWindow = 32;
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 260;
  localparam int SettleCycles = 8;
  localparam int HoldOffCycles = 400;
  // The block defines no name for the fourth event code; it must be ignored.
  localparam logic [gbn_pkg::KindW-1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic [gbn_pkg::FrameW-1:0] frame_number;
    logic                       end_marker;
    logic                       last;
  } frame_item_t;

  // Tracks the sender window and holds the frame items the block still owes.
  class sender_window_tracker;
    logic [gbn_pkg::WinW-1:0]   window_size;
    logic [gbn_pkg::FrameW-1:0] frame_count;
    int unsigned                base;
    int unsigned                top;
    int unsigned                next_frame;
    bit                         active;
    frame_item_t                pending[$];
    int unsigned                errors;

    function new();
      window_size = gbn_pkg::WindowSizeReset;
      frame_count = gbn_pkg::FrameCountReset;
      base = 0;
      top = 0;
      next_frame = 0;
      active = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [gbn_pkg::CfgIdxW-1:0] index,
                            logic [gbn_pkg::CfgDataW-1:0] data);
      if (index == gbn_pkg::CfgWindowSize) begin
        window_size = data[gbn_pkg::WinW-1:0];
      end else begin
        frame_count = data;
      end
    endfunction

    // Frames base through top, never more than a full window.
    function void queue_window(ref frame_item_t burst[$]);
      int n;
      n = 0;
      for (int unsigned f = base; f <= top && n < MaxWindow; f++) begin
        burst.push_back('{gbn_pkg::FrameW'(f), 1'b0, 1'b0});
        n++;
      end
      next_frame = (top + 1) & 32'hFFFF;
    endfunction

    // Returns 1 unless the block is expected to ignore the event.
    function bit accept_event(logic [gbn_pkg::KindW-1:0] kind,
                              logic [gbn_pkg::AckW-1:0] ack);
      frame_item_t burst[$];
      int unsigned ws;
      int unsigned count;
      count = frame_count;
      if (kind == gbn_pkg::KindStart) begin
        ws = window_size;
        if (ws == 0) ws = 1;
        if (ws > MaxWindow) ws = MaxWindow;
        base = 0;
        next_frame = 0;
        if (count == 0) begin
          top = 0;
          active = 1'b0;
          burst.push_back('{gbn_pkg::EndFrame, 1'b1, 1'b0});
        end else begin
          top = ((ws < count) ? ws : count) - 1;
          active = 1'b1;
          queue_window(burst);
        end
      end else if ((kind == gbn_pkg::KindAck || kind == gbn_pkg::KindTimeout) && active) begin
        if (kind == gbn_pkg::KindAck && ack == gbn_pkg::AckW'(base + 1)) begin
          base++;
          if (base >= count) begin
            active = 1'b0;
            burst.push_back('{gbn_pkg::EndFrame, 1'b1, 1'b0});
          end else if (top + 1 < count) begin
            top++;
            burst.push_back('{gbn_pkg::FrameW'(top), 1'b0, 1'b0});
            next_frame = (top + 1) & 32'hFFFF;
          end
        end else begin
          queue_window(burst);
        end
      end else begin
        return 1'b0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
      return 1'b1;
    endfunction

    function void check_frame(logic [gbn_pkg::FrameW-1:0] frame_number, logic end_marker,
                              logic last);
      frame_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: frame %h end %b last %b",
                 $time, frame_number, end_marker, last);
        return;
      end
      want = pending.pop_front();
      if (want !== {frame_number, end_marker, last}) begin
        errors++;
        $display("%0t: mismatch: expected frame %h end %b last %b, got frame %h end %b last %b",
                 $time, want.frame_number, want.end_marker, want.last,
                 frame_number, end_marker, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [gbn_pkg::CfgIdxW-1:0] cfg_index;
  logic [gbn_pkg::CfgDataW-1:0] cfg_wdata;

  gbn_evt_if evt_bus();
  gbn_res_if res_bus();

  go_back_n_sender_window_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_bus),
    .res_o       (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  sender_window_tracker tracker = new();

  // Idle and stall rates in percent, changed per phase by the stimulus.
  int send_idle_pct = 0;
  int stall_pct = 0;
  // A nonzero value asks the receiver to hold ready low for that many cycles.
  int hold_cycles_req = 0;
  int cycle_count = 0;

  always #5 clk_i = ~clk_i;

  // Watchdog: a correct run ends far below this count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d frame items outstanding", $time, tracker.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here when asked for.
  initial begin : receiver
    int remaining;
    remaining = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        remaining = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (remaining != 0) begin
        remaining--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every accepted result item is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      tracker.check_frame(res_bus.frame_number, res_bus.end_marker, res_bus.last);
    end
  end

  // Offers one event and waits for it to be taken. Valid stays high on return, so that
  // back-to-back events need no second assignment in the same step.
  task automatic send_event(logic [gbn_pkg::KindW-1:0] kind, logic [gbn_pkg::AckW-1:0] ack,
                            output bit live);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.kind <= kind;
    evt_bus.ack_number <= ack;
    @(posedge clk_i);
    while (!evt_bus.ready) @(posedge clk_i);
    live = tracker.accept_event(kind, ack);
  endtask

  // Stops offering events and waits for every owed result, then lets the settle period pass
  // before anything else.
  task automatic drain_results();
    evt_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive cycles; only called while the block is idle.
  task automatic write_regs(logic [gbn_pkg::WinW-1:0] ws, logic [gbn_pkg::FrameW-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= gbn_pkg::CfgWindowSize;
    cfg_wdata <= gbn_pkg::CfgDataW'(ws);
    @(posedge clk_i);
    tracker.write_reg(gbn_pkg::CfgWindowSize, gbn_pkg::CfgDataW'(ws));
    cfg_index <= gbn_pkg::CfgFrameCount;
    cfg_wdata <= count;
    @(posedge clk_i);
    tracker.write_reg(gbn_pkg::CfgFrameCount, count);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // One session: a start, then mostly in-order acknowledgements with some noise mixed in.
  task automatic run_session(ref int counted);
    int unsigned steps;
    int unsigned pick;
    logic [gbn_pkg::KindW-1:0] kind;
    logic [gbn_pkg::AckW-1:0] ack;
    bit live;
    send_event(gbn_pkg::KindStart, gbn_pkg::AckW'($urandom), live);
    counted += live;
    steps = $urandom_range(24, 4);
    repeat (steps) begin
      pick = $urandom_range(99);
      ack = gbn_pkg::AckW'($urandom);
      if (pick < 65) begin
        // In-order acknowledgement, or a fresh start once the transfer has ended.
        kind = tracker.active ? gbn_pkg::KindAck : gbn_pkg::KindStart;
        ack = gbn_pkg::AckW'(tracker.base + 1);
      end else if (pick < 75) begin
        kind = gbn_pkg::KindTimeout;
      end else if (pick < 85) begin
        // Near-miss acknowledgements force a rewind.
        kind = gbn_pkg::KindAck;
        case ($urandom_range(2))
          0: ack = gbn_pkg::AckW'(tracker.base);
          1: ack = gbn_pkg::AckW'(tracker.base + 2);
          default: ;
        endcase
      end else if (pick < 90) begin
        kind = KindUnused;
      end else if (pick < 94) begin
        kind = gbn_pkg::KindStart;
      end else begin
        kind = gbn_pkg::KindW'($urandom);
      end
      send_event(kind, ack, live);
      counted += live;
    end
  endtask

  initial begin : stimulus
    bit live;
    int phase_items;
    int phase_quota;
    logic [gbn_pkg::WinW-1:0] ws;
    logic [gbn_pkg::FrameW-1:0] count;
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 77, 0, 31};
    recv_pct = '{0, 0, 77, 31};
    phase_quota = RandomItems / 4;

    evt_bus.valid = 1'b0;
    evt_bus.kind = gbn_pkg::KindStart;
    evt_bus.ack_number = '0;
    cfg_we = 1'b0;
    cfg_index = gbn_pkg::CfgWindowSize;
    cfg_wdata = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset configuration: window of 4 over 16 frames.
    // Events while idle and the unused code produce nothing.
    send_event(gbn_pkg::KindAck, 16'd1, live);
    send_event(gbn_pkg::KindTimeout, 16'hFFFF, live);
    send_event(KindUnused, 16'h0000, live);
    send_event(gbn_pkg::KindStart, 16'h0000, live);      // frames 0..3
    send_event(gbn_pkg::KindAck, 16'd1, live);           // slide, frame 4
    send_event(gbn_pkg::KindAck, 16'd0, live);           // wrong ack, rewind 1..4
    send_event(gbn_pkg::KindTimeout, 16'd0, live);       // rewind 1..4
    send_event(KindUnused, 16'd2, live);                 // ignored while active
    send_event(gbn_pkg::KindStart, 16'h5555, live);      // restart from frame 0
    drain_results();

    // Window size zero acts as one; a single frame ends on its first acknowledgement.
    write_regs(6'd0, 16'd1);
    send_event(gbn_pkg::KindStart, 16'h0000, live);
    send_event(gbn_pkg::KindAck, 16'd1, live);           // end marker
    send_event(gbn_pkg::KindAck, 16'd2, live);           // idle again, ignored
    drain_results();

    // A frame count of zero gives only the end marker.
    write_regs(6'd1, 16'd0);
    send_event(gbn_pkg::KindStart, 16'h0000, live);
    drain_results();

    // Oversized window is clipped to the maximum; largest frame count.
    write_regs(6'd63, 16'hFFFF);
    send_event(gbn_pkg::KindStart, 16'h0000, live);      // frames 0..31
    send_event(gbn_pkg::KindAck, 16'hFFFF, live);        // rewind 0..31
    send_event(gbn_pkg::KindAck, 16'd1, live);           // frame 32
    drain_results();

    // Window wider than the transfer: the top is clipped, and slides admit nothing new.
    write_regs(6'd32, 16'd5);
    send_event(gbn_pkg::KindStart, 16'h0000, live);      // frames 0..4
    send_event(gbn_pkg::KindAck, 16'd1, live);
    send_event(gbn_pkg::KindAck, 16'd2, live);
    send_event(gbn_pkg::KindAck, 16'd3, live);
    send_event(gbn_pkg::KindAck, 16'd4, live);
    send_event(gbn_pkg::KindAck, 16'd5, live);           // end marker
    drain_results();

    // Back-pressure: the receiver holds off while the sender keeps offering events,
    // so the command queue fills and the event channel stalls. Then the sender pauses
    // until everything owed has come out.
    write_regs(6'd32, 16'd40);
    hold_cycles_req = HoldOffCycles;
    send_event(gbn_pkg::KindStart, 16'h0000, live);
    repeat (6) begin
      send_event(gbn_pkg::KindTimeout, 16'h0000, live);
      send_event(gbn_pkg::KindAck, gbn_pkg::AckW'(tracker.base + 1), live);
    end
    drain_results();

    // Random part, one phase per idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      stall_pct = recv_pct[p];
      phase_items = 0;
      while (phase_items < phase_quota) begin
        drain_results();
        case ($urandom_range(9))
          0: ws = 6'd0;
          1: ws = 6'd63;
          2: ws = 6'd32;
          3: ws = gbn_pkg::WinW'($urandom_range(63));
          default: ws = gbn_pkg::WinW'($urandom_range(8, 1));
        endcase
        case ($urandom_range(19))
          0: count = 16'd0;
          1: count = 16'd1;
          2: count = gbn_pkg::FrameW'($urandom_range(65535, 25));
          3: count = 16'hFFFF;
          default: count = gbn_pkg::FrameW'($urandom_range(24, 2));
        endcase
        write_regs(ws, count);
        run_session(phase_items);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (tracker.pending.size() != 0) begin
        $display("%0t: %0d frame items never arrived", $time, tracker.pending.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gbn_pkg.sv
rtl/gbn_if.sv
rtl/gbn_front.sv
rtl/gbn_cmd_fifo.sv
rtl/gbn_back.sv
rtl/go_back_n_sender_window_top.sv
rtl/gbn_checker.sv
tb/sv/tb_top.sv
